// ===== rtl/rltt_pkg.sv =====
package rltt_pkg;

   // log geometry
   localparam int LOG_SLOTS = 30;
   localparam int CNT_W     = $clog2(LOG_SLOTS + 1);
   localparam int IDX_W     = (LOG_SLOTS > 1) ? $clog2(LOG_SLOTS) : 1;

   // field widths
   localparam int FUNC_W    = 2;
   localparam int BLOCK_W   = 32;
   localparam int STATUS_W  = 3;
   localparam int ACTION_W  = 3;
   localparam int SLOT_W    = 5;
   localparam int AREA_W    = 16;
   localparam int MAXOP_W   = 5;
   localparam int OPEN_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   // request functions
   localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_END   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_WAIT     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_BEGIN = 3'd4;

   // response actions
   localparam logic [ACTION_W-1:0] ACT_NONE    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_COPY    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_HEADER  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_INSTALL = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_AREA  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_OP    = 2'd2;

   // configuration reset values
   localparam logic [BLOCK_W-1:0] LOG_START_RST = 32'd2;
   localparam logic [AREA_W-1:0]  LOG_AREA_RST  = 16'd31;
   localparam logic [MAXOP_W-1:0] MAX_OP_RST    = 5'd10;

   // one result item
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ACTION_W-1:0] action;
      logic [BLOCK_W-1:0]  source_block;
      logic [BLOCK_W-1:0]  dest_block;
      logic [SLOT_W-1:0]   slot;
      logic [SLOT_W-1:0]   header_count;
      logic                last;
   } rsp_type;

endpackage

// ===== rtl/rltt_req_if.sv =====
interface rltt_req_if;
   logic                             valid;
   logic                             ready;
   logic [rltt_pkg::FUNC_W-1:0]      func;
   logic [rltt_pkg::BLOCK_W-1:0]     block_number;

   modport source (output valid, func, block_number, input ready);
   modport sink   (input valid, func, block_number, output ready);
endinterface

// ===== rtl/rltt_rsp_if.sv =====
interface rltt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rltt_pkg::STATUS_W-1:0]    status;
   logic [rltt_pkg::ACTION_W-1:0]    action;
   logic [rltt_pkg::BLOCK_W-1:0]     source_block;
   logic [rltt_pkg::BLOCK_W-1:0]     dest_block;
   logic [rltt_pkg::SLOT_W-1:0]      slot;
   logic [rltt_pkg::SLOT_W-1:0]      header_count;
   logic                             last;

   modport source (output valid, status, action, source_block, dest_block, slot,
                   header_count, last, input ready);
   modport sink   (input valid, status, action, source_block, dest_block, slot,
                   header_count, last, output ready);
endinterface

// ===== rtl/redo_log_transaction_tracker.sv =====
// Redo-log transaction tracker. Takes one request at a time (begin, end or a
// block write) and answers through a registered response stage. The logged
// block numbers live in a 30-entry synchronous memory with one read port.
// Begin, end without commit and rejected writes go from idle to the put state,
// which waits for the response stage. An accepted write into a non-empty log
// scans the logged slots one per cycle through the memory read port. An end
// that commits streams 2 * logged_count + 2 responses at one per cycle while
// the sink keeps ready high. The user must write config registers through the
// csr_ port only while no request is in flight; the block does not enforce it.
module redo_log_transaction_tracker (
   input  logic                              clock,
   input  logic                              reset,
   rltt_req_if.sink                          req,
   rltt_rsp_if.source                        rsp,
   input  logic                              csr_wr_en,
   input  logic [rltt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rltt_pkg::CSR_DAT_W-1:0]    csr_wr_data
);

   localparam int CNT_W = rltt_pkg::CNT_W;
   localparam int IDX_W = rltt_pkg::IDX_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PUT  = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_COPY = 3'd3;
   localparam logic [2:0] S_HDR  = 3'd4;
   localparam logic [2:0] S_INST = 3'd5;
   localparam logic [2:0] S_CLR  = 3'd6;

   logic [2:0]                      state_ff, state_in;
   logic [rltt_pkg::OPEN_W-1:0]     open_ff, open_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [CNT_W-1:0]                ptr_ff, ptr_in;
   logic [rltt_pkg::BLOCK_W-1:0]    blk_ff, blk_in;
   rltt_pkg::rsp_type               pend_ff, pend_in;
   rltt_pkg::rsp_type               out_ff, out_in;
   logic                            out_valid_ff, out_valid_in;

   logic [rltt_pkg::BLOCK_W-1:0]    log_start_ff;
   logic [rltt_pkg::AREA_W-1:0]     log_area_ff;
   logic [rltt_pkg::MAXOP_W-1:0]    max_op_ff;

   logic [rltt_pkg::BLOCK_W-1:0]    mem [rltt_pkg::LOG_SLOTS];
   logic [rltt_pkg::BLOCK_W-1:0]    rdata_ff;
   logic                            mem_we;
   logic [IDX_W-1:0]                mem_waddr;
   logic [rltt_pkg::BLOCK_W-1:0]    mem_wdata;
   logic [IDX_W-1:0]                mem_raddr;

   logic                            accept;
   logic                            out_free;
   logic                            out_load;
   logic [8:0]                      open_inc;
   logic [13:0]                     resv;
   logic [14:0]                     need;
   logic                            fits;
   logic                            log_full;
   logic                            at_end;
   logic [rltt_pkg::BLOCK_W-1:0]    slot_block;
   rltt_pkg::rsp_type               res;

   assign accept    = req.valid && req.ready;
   assign out_free  = !out_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE);

   // reservation check for begin
   assign open_inc = {1'b0, open_ff} + 9'd1;
   assign resv     = 14'(open_inc) * 14'(max_op_ff);
   assign need     = 15'(resv) + 15'(count_ff);
   assign fits     = (need <= 15'(rltt_pkg::LOG_SLOTS));

   // log full check for write
   assign log_full = (count_ff >= CNT_W'(rltt_pkg::LOG_SLOTS)) ||
                     ((17'(count_ff) + 17'd1) >= 17'(log_area_ff));

   assign at_end     = (ptr_ff == (count_ff - CNT_W'(1)));
   assign slot_block = log_start_ff + rltt_pkg::BLOCK_W'(ptr_ff) + 32'd1;
   assign mem_raddr  = ptr_in[IDX_W-1:0];

   // request sequencing
   always_comb begin
      state_in  = state_ff;
      open_in   = open_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      blk_in    = blk_ff;
      pend_in   = pend_ff;
      out_load  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = count_ff[IDX_W-1:0];
      mem_wdata = blk_ff;

      res.status       = rltt_pkg::ST_OK;
      res.action       = rltt_pkg::ACT_NONE;
      res.source_block = '0;
      res.dest_block   = '0;
      res.slot         = '0;
      res.header_count = rltt_pkg::SLOT_W'(count_ff);
      res.last         = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               blk_in   = req.block_number;
               state_in = S_PUT;
               case (req.func)
                  rltt_pkg::FUNC_BEGIN: begin
                     if (!fits || open_ff == 8'hFF) begin
                        res.status = rltt_pkg::ST_WAIT;
                     end else begin
                        open_in = open_ff + 8'd1;
                     end
                  end
                  rltt_pkg::FUNC_WRITE: begin
                     if (log_full) begin
                        res.status = rltt_pkg::ST_TOO_BIG;
                     end else if (open_ff == '0) begin
                        res.status = rltt_pkg::ST_OUTSIDE;
                     end else if (count_ff == '0) begin
                        mem_we           = 1'b1;
                        mem_wdata        = req.block_number;
                        count_in         = CNT_W'(1);
                        res.header_count = rltt_pkg::SLOT_W'(1);
                     end else begin
                        ptr_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  rltt_pkg::FUNC_END: begin
                     if (open_ff == '0) begin
                        res.status = rltt_pkg::ST_NO_BEGIN;
                     end else begin
                        open_in = open_ff - 8'd1;
                        if (open_ff == 8'd1 && count_ff != '0) begin
                           ptr_in   = '0;
                           state_in = S_COPY;
                        end
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
               pend_in = res;
            end
         end
         S_PUT: begin
            if (out_free) begin
               out_load = 1'b1;
               res      = pend_ff;
               state_in = S_IDLE;
            end
         end
         // one logged slot compared per cycle
         S_SCAN: begin
            if (rdata_ff == blk_ff) begin
               res.slot = rltt_pkg::SLOT_W'(ptr_ff);
               pend_in  = res;
               state_in = S_PUT;
            end else if (at_end) begin
               mem_we           = 1'b1;
               count_in         = count_ff + CNT_W'(1);
               res.slot         = rltt_pkg::SLOT_W'(count_ff);
               res.header_count = rltt_pkg::SLOT_W'(count_ff + CNT_W'(1));
               pend_in          = res;
               state_in         = S_PUT;
            end else begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
         end
         S_COPY: begin
            if (out_free) begin
               out_load         = 1'b1;
               res.action       = rltt_pkg::ACT_COPY;
               res.source_block = rdata_ff;
               res.dest_block   = slot_block;
               res.slot         = rltt_pkg::SLOT_W'(ptr_ff);
               res.last         = 1'b0;
               if (at_end) begin
                  ptr_in   = '0;
                  state_in = S_HDR;
               end else begin
                  ptr_in = ptr_ff + CNT_W'(1);
               end
            end
         end
         S_HDR: begin
            if (out_free) begin
               out_load       = 1'b1;
               res.action     = rltt_pkg::ACT_HEADER;
               res.dest_block = log_start_ff;
               res.last       = 1'b0;
               state_in       = S_INST;
            end
         end
         S_INST: begin
            if (out_free) begin
               out_load         = 1'b1;
               res.action       = rltt_pkg::ACT_INSTALL;
               res.source_block = slot_block;
               res.dest_block   = rdata_ff;
               res.slot         = rltt_pkg::SLOT_W'(ptr_ff);
               res.last         = 1'b0;
               if (at_end) begin
                  ptr_in   = '0;
                  state_in = S_CLR;
               end else begin
                  ptr_in = ptr_ff + CNT_W'(1);
               end
            end
         end
         S_CLR: begin
            if (out_free) begin
               out_load         = 1'b1;
               res.action       = rltt_pkg::ACT_CLEAR;
               res.dest_block   = log_start_ff;
               res.header_count = '0;
               count_in         = '0;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response stage
   always_comb begin
      out_in       = out_load ? res : out_ff;
      out_valid_in = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.status       = out_ff.status;
   assign rsp.action       = out_ff.action;
   assign rsp.source_block = out_ff.source_block;
   assign rsp.dest_block   = out_ff.dest_block;
   assign rsp.slot         = out_ff.slot;
   assign rsp.header_count = out_ff.header_count;
   assign rsp.last         = out_ff.last;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         log_start_ff <= rltt_pkg::LOG_START_RST;
         log_area_ff  <= rltt_pkg::LOG_AREA_RST;
         max_op_ff    <= rltt_pkg::MAX_OP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            rltt_pkg::CSR_LOG_START: log_start_ff <= csr_wr_data;
            rltt_pkg::CSR_LOG_AREA:  log_area_ff  <= csr_wr_data[rltt_pkg::AREA_W-1:0];
            rltt_pkg::CSR_MAX_OP:    max_op_ff    <= csr_wr_data[rltt_pkg::MAXOP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // logged block memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(rltt_pkg::LOG_SLOTS))
      else $error("logged count beyond slot count");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY || state_ff == S_INST || state_ff == S_SCAN) |->
      (ptr_ff < count_ff))
      else $error("slot pointer outside logged range");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR && out_free) |=> (count_ff == '0 && state_ff == S_IDLE))
      else $error("commit did not empty the log");

   a_open_only_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> $stable(open_ff))
      else $error("open operation count changed while busy");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 80;

   // one request waiting to be driven
   typedef struct {
      logic [rltt_pkg::FUNC_W-1:0]  func;
      logic [rltt_pkg::BLOCK_W-1:0] block_number;
      bit                           drain;
   } log_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_wr_en   = 1'b0;
   logic [rltt_pkg::CSR_IDX_W-1:0] csr_index   = rltt_pkg::CSR_LOG_START;
   logic [rltt_pkg::CSR_DAT_W-1:0] csr_wr_data = '0;

   rltt_req_if req_ch ();
   rltt_rsp_if rsp_ch ();

   redo_log_transaction_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // tracker mirror: configuration and log state
   logic [rltt_pkg::BLOCK_W-1:0] cfg_log_start;
   logic [rltt_pkg::AREA_W-1:0]  cfg_log_area;
   logic [rltt_pkg::MAXOP_W-1:0] cfg_max_op;
   logic [rltt_pkg::OPEN_W-1:0]  open_ops;
   logic [rltt_pkg::CNT_W-1:0]   logged_cnt;
   logic [rltt_pkg::BLOCK_W-1:0] logged_blk [rltt_pkg::LOG_SLOTS];

   log_req_type        pending_req [$];
   rltt_pkg::rsp_type  expected_rsp [$];
   logic [rltt_pkg::BLOCK_W-1:0] block_pool [8];

   bit req_taken;
   bit rsp_taken;
   int send_gap;
   int rsp_wait;
   bit send_no_idle;
   bit rsp_no_idle;
   int idle_cycles;
   int mismatches;
   int items_queued;

   function automatic int draw_gap(input bit no_idle);
      return no_idle ? 0 : $urandom_range(0, 11);
   endfunction

   function automatic logic [rltt_pkg::BLOCK_W-1:0] rand_block();
      if ($urandom_range(0, 1) == 0)
         return block_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic push_result(input logic [rltt_pkg::STATUS_W-1:0] status,
                              input logic [rltt_pkg::ACTION_W-1:0] action,
                              input logic [rltt_pkg::BLOCK_W-1:0] src,
                              input logic [rltt_pkg::BLOCK_W-1:0] dst,
                              input logic [rltt_pkg::SLOT_W-1:0] slot,
                              input logic [rltt_pkg::SLOT_W-1:0] hc,
                              input logic last);
      rltt_pkg::rsp_type r;
      r.status       = status;
      r.action       = action;
      r.source_block = src;
      r.dest_block   = dst;
      r.slot         = slot;
      r.header_count = hc;
      r.last         = last;
      expected_rsp.push_back(r);
   endtask

   // work out the responses that one accepted request causes
   task automatic predict_log_response(input logic [rltt_pkg::FUNC_W-1:0] func,
                                       input logic [rltt_pkg::BLOCK_W-1:0] blk);
      int unsigned need;
      int unsigned hit;
      int unsigned n;
      int i;
      case (func)
         rltt_pkg::FUNC_BEGIN: begin
            // reservation covers every open operation plus the new one
            need = logged_cnt + (open_ops + 32'd1) * cfg_max_op;
            if (need > rltt_pkg::LOG_SLOTS || open_ops == 8'hFF) begin
               push_result(rltt_pkg::ST_WAIT, rltt_pkg::ACT_NONE, '0, '0, '0,
                           logged_cnt, 1'b1);
            end else begin
               open_ops = open_ops + 8'd1;
               push_result(rltt_pkg::ST_OK, rltt_pkg::ACT_NONE, '0, '0, '0,
                           logged_cnt, 1'b1);
            end
         end
         rltt_pkg::FUNC_WRITE: begin
            if (logged_cnt >= rltt_pkg::LOG_SLOTS ||
                logged_cnt + 32'd1 >= cfg_log_area) begin
               push_result(rltt_pkg::ST_TOO_BIG, rltt_pkg::ACT_NONE, '0, '0, '0,
                           logged_cnt, 1'b1);
            end else if (open_ops == 0) begin
               push_result(rltt_pkg::ST_OUTSIDE, rltt_pkg::ACT_NONE, '0, '0, '0,
                           logged_cnt, 1'b1);
            end else begin
               // a block already logged keeps its slot
               hit = logged_cnt;
               for (i = 0; i < logged_cnt; i++)
                  if (logged_blk[i] == blk && hit == logged_cnt)
                     hit = i;
               if (hit == logged_cnt) begin
                  logged_blk[hit] = blk;
                  logged_cnt = logged_cnt + 1'b1;
               end
               push_result(rltt_pkg::ST_OK, rltt_pkg::ACT_NONE, '0, '0,
                           rltt_pkg::SLOT_W'(hit), logged_cnt, 1'b1);
            end
         end
         rltt_pkg::FUNC_END: begin
            if (open_ops == 0) begin
               push_result(rltt_pkg::ST_NO_BEGIN, rltt_pkg::ACT_NONE, '0, '0, '0,
                           logged_cnt, 1'b1);
            end else begin
               open_ops = open_ops - 8'd1;
               if (open_ops != 0 || logged_cnt == 0) begin
                  push_result(rltt_pkg::ST_OK, rltt_pkg::ACT_NONE, '0, '0, '0,
                              logged_cnt, 1'b1);
               end else begin
                  // group commit: copy, header, install, clear
                  n = logged_cnt;
                  for (i = 0; i < n; i++)
                     push_result(rltt_pkg::ST_OK, rltt_pkg::ACT_COPY, logged_blk[i],
                                 cfg_log_start + rltt_pkg::BLOCK_W'(i) + 32'd1,
                                 rltt_pkg::SLOT_W'(i), rltt_pkg::SLOT_W'(n), 1'b0);
                  push_result(rltt_pkg::ST_OK, rltt_pkg::ACT_HEADER, '0, cfg_log_start,
                              '0, rltt_pkg::SLOT_W'(n), 1'b0);
                  for (i = 0; i < n; i++)
                     push_result(rltt_pkg::ST_OK, rltt_pkg::ACT_INSTALL,
                                 cfg_log_start + rltt_pkg::BLOCK_W'(i) + 32'd1,
                                 logged_blk[i], rltt_pkg::SLOT_W'(i),
                                 rltt_pkg::SLOT_W'(n), 1'b0);
                  logged_cnt = '0;
                  push_result(rltt_pkg::ST_OK, rltt_pkg::ACT_CLEAR, '0, cfg_log_start,
                              '0, '0, 1'b1);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic push_item(input logic [rltt_pkg::FUNC_W-1:0] func,
                            input logic [rltt_pkg::BLOCK_W-1:0] blk, input bit drain);
      log_req_type it;
      it.func         = func;
      it.block_number = blk;
      it.drain        = drain;
      pending_req.push_back(it);
      items_queued++;
   endtask

   task automatic write_csr(input logic [rltt_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rltt_pkg::CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         rltt_pkg::CSR_LOG_START: cfg_log_start = data;
         rltt_pkg::CSR_LOG_AREA:  cfg_log_area  = data[rltt_pkg::AREA_W-1:0];
         rltt_pkg::CSR_MAX_OP:    cfg_max_op    = data[rltt_pkg::MAXOP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait until every request is sent and every response has come back
   task automatic wait_idle();
      while (pending_req.size() != 0 || req_ch.valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // well-formed transactions with random content, plus some noise
   task automatic add_random_items(input int target, input int ops_max);
      int start;
      int ops;
      int nwr;
      int k;
      bit drain;
      start = items_queued;
      while (items_queued - start < target) begin
         if ($urandom_range(0, 9) == 0) begin
            push_item(rltt_pkg::FUNC_W'($urandom_range(0, 3)), $urandom, 1'b0);
         end else begin
            ops   = $urandom_range(1, ops_max);
            drain = ($urandom_range(0, 4) == 0);
            for (k = 0; k < ops; k++)
               push_item(rltt_pkg::FUNC_BEGIN, $urandom, drain && k == 0);
            nwr = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 34)
                                              : $urandom_range(0, 8);
            for (k = 0; k < nwr; k++) begin
               push_item(rltt_pkg::FUNC_WRITE, rand_block(), 1'b0);
               if ($urandom_range(0, 15) == 0) begin
                  push_item(rltt_pkg::FUNC_BEGIN, $urandom, 1'b0);
                  ops++;
               end
            end
            // broken sequence: one end too many or too few
            if ($urandom_range(0, 7) == 0)
               ops = ($urandom_range(0, 1) == 0) ? ops + 1 : ops - 1;
            for (k = 0; k < ops; k++)
               push_item(rltt_pkg::FUNC_END, $urandom, 1'b0);
         end
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_ch.valid && !req_taken) begin
            // hold until the transfer completes
         end else if (send_gap > 0) begin
            req_ch.valid <= 1'b0;
            send_gap--;
         end else if (pending_req.size() != 0 &&
                      !(pending_req[0].drain && expected_rsp.size() != 0)) begin
            req_ch.valid        <= 1'b1;
            req_ch.func         <= pending_req[0].func;
            req_ch.block_number <= pending_req[0].block_number;
            void'(pending_req.pop_front());
            if ($urandom_range(0, 15) == 0)
               send_no_idle = !send_no_idle;
            send_gap = draw_gap(send_no_idle);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response sink with random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 15) == 0)
               rsp_no_idle = !rsp_no_idle;
            rsp_wait = draw_gap(rsp_no_idle);
         end
         if (rsp_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // monitor: predict on request transfer, check on response transfer
   always @(posedge clock) begin
      rltt_pkg::rsp_type got;
      rltt_pkg::rsp_type want;
      req_taken = !reset && req_ch.valid && req_ch.ready;
      rsp_taken = !reset && rsp_ch.valid && rsp_ch.ready;
      if (req_taken)
         predict_log_response(req_ch.func, req_ch.block_number);
      if (rsp_taken) begin
         got.status       = rsp_ch.status;
         got.action       = rsp_ch.action;
         got.source_block = rsp_ch.source_block;
         got.dest_block   = rsp_ch.dest_block;
         got.slot         = rsp_ch.slot;
         got.header_count = rsp_ch.header_count;
         got.last         = rsp_ch.last;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"unexpected response: st=%0d act=%0d src=%h dst=%h",
                         " slot=%0d hc=%0d last=%0d"},
                        got.status, got.action, got.source_block, got.dest_block,
                        got.slot, got.header_count, got.last);
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status || got.action !== want.action ||
                got.source_block !== want.source_block ||
                got.dest_block !== want.dest_block || got.slot !== want.slot ||
                got.header_count !== want.header_count || got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display({"mismatch exp: st=%0d act=%0d src=%h dst=%h",
                            " slot=%0d hc=%0d last=%0d"},
                           want.status, want.action, want.source_block, want.dest_block,
                           want.slot, want.header_count, want.last);
                  $display({"         got: st=%0d act=%0d src=%h dst=%h",
                            " slot=%0d hc=%0d last=%0d"},
                           got.status, got.action, got.source_block, got.dest_block,
                           got.slot, got.header_count, got.last);
               end
            end
         end
      end
      // watchdog on cycles with no transfer at all
      if (req_taken || rsp_taken)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int i;
      req_ch.valid        = 1'b0;
      req_ch.func         = rltt_pkg::FUNC_BEGIN;
      req_ch.block_number = '0;
      rsp_ch.ready        = 1'b0;
      cfg_log_start = rltt_pkg::LOG_START_RST;
      cfg_log_area  = rltt_pkg::LOG_AREA_RST;
      cfg_max_op    = rltt_pkg::MAX_OP_RST;
      open_ops      = '0;
      logged_cnt    = '0;
      for (i = 0; i < rltt_pkg::LOG_SLOTS; i++)
         logged_blk[i] = '0;
      block_pool[0] = 32'h0000_0000;
      block_pool[1] = 32'hFFFF_FFFF;
      block_pool[2] = 32'h0000_0001;
      block_pool[3] = 32'h8000_0000;
      for (i = 4; i < 8; i++)
         block_pool[i] = $urandom;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part under reset configuration
      push_item(rltt_pkg::FUNC_END, 32'h0, 1'b0);            // end without begin
      push_item(rltt_pkg::FUNC_WRITE, 32'h0, 1'b0);          // write outside transaction
      push_item(2'd3, 32'hDEAD_BEEF, 1'b0);                  // undefined function, ignored
      push_item(rltt_pkg::FUNC_BEGIN, 32'h0, 1'b0);
      push_item(rltt_pkg::FUNC_BEGIN, 32'hFFFF_FFFF, 1'b0);
      push_item(rltt_pkg::FUNC_BEGIN, 32'h0, 1'b0);          // reservation exactly full
      push_item(rltt_pkg::FUNC_BEGIN, 32'h0, 1'b0);          // does not fit: wait
      push_item(rltt_pkg::FUNC_WRITE, 32'h0000_0000, 1'b0);
      push_item(rltt_pkg::FUNC_WRITE, 32'hFFFF_FFFF, 1'b0);
      push_item(rltt_pkg::FUNC_WRITE, 32'h0000_0000, 1'b0);  // repeated block merges
      push_item(rltt_pkg::FUNC_WRITE, 32'h5555_AAAA, 1'b0);
      push_item(rltt_pkg::FUNC_END, 32'h0, 1'b0);            // operations still open
      push_item(rltt_pkg::FUNC_END, 32'h0, 1'b0);
      push_item(rltt_pkg::FUNC_BEGIN, 32'h0, 1'b0);          // fits with logged blocks
      push_item(rltt_pkg::FUNC_END, 32'h0, 1'b0);
      push_item(rltt_pkg::FUNC_END, 32'h0, 1'b0);            // commit
      push_item(rltt_pkg::FUNC_BEGIN, 32'h0, 1'b0);
      push_item(rltt_pkg::FUNC_END, 32'h0, 1'b0);            // empty commit
      push_item(rltt_pkg::FUNC_BEGIN, 32'h0, 1'b1);          // sender drains first
      push_item(rltt_pkg::FUNC_WRITE, 32'hAAAA_5555, 1'b0);
      push_item(2'd3, 32'h1234_5678, 1'b0);
      push_item(rltt_pkg::FUNC_END, 32'h0, 1'b1);

      // wrapping log address, huge area, one block per operation
      wait_idle();
      write_csr(rltt_pkg::CSR_LOG_START, 32'hFFFF_FFF0);
      write_csr(rltt_pkg::CSR_LOG_AREA, 32'h0000_FFFF);
      write_csr(rltt_pkg::CSR_MAX_OP, 32'd1);
      add_random_items(70, 8);

      // smallest log area: one slot only
      wait_idle();
      write_csr(rltt_pkg::CSR_LOG_START, 32'h0);
      write_csr(rltt_pkg::CSR_LOG_AREA, 32'd2);
      write_csr(rltt_pkg::CSR_MAX_OP, 32'd1);
      push_item(rltt_pkg::FUNC_BEGIN, 32'h0, 1'b0);
      push_item(rltt_pkg::FUNC_WRITE, 32'h0000_0007, 1'b0);
      push_item(rltt_pkg::FUNC_WRITE, 32'h0000_0008, 1'b0);  // log full: too big
      push_item(rltt_pkg::FUNC_WRITE, 32'h0000_0007, 1'b0);  // full check comes first
      push_item(rltt_pkg::FUNC_END, 32'h0, 1'b0);
      add_random_items(35, 3);

      // largest reservation: every begin waits
      wait_idle();
      write_csr(rltt_pkg::CSR_LOG_START, 32'hFFFF_FFFF);
      write_csr(rltt_pkg::CSR_LOG_AREA, 32'd31);
      write_csr(rltt_pkg::CSR_MAX_OP, 32'd31);
      add_random_items(20, 2);

      // random setting
      wait_idle();
      write_csr(rltt_pkg::CSR_LOG_START, $urandom);
      write_csr(rltt_pkg::CSR_LOG_AREA, $urandom_range(2, 40));
      write_csr(rltt_pkg::CSR_MAX_OP, $urandom_range(1, 15));
      add_random_items(60, 4);

      // small reservation, mid-size area, maximum start
      wait_idle();
      write_csr(rltt_pkg::CSR_LOG_START, 32'hFFFF_FFFF);
      write_csr(rltt_pkg::CSR_LOG_AREA, 32'd17);
      write_csr(rltt_pkg::CSR_MAX_OP, 32'd3);
      add_random_items(50, 5);

      wait_idle();
      if (expected_rsp.size() != 0)
         mismatches++;
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
